// ===== sv/ciir_pkg.sv =====
// ----------------------------------------------------------------------------
// ciir_pkg
// Shared widths, register indexes and the control bundle of the shared MAC.
// ----------------------------------------------------------------------------
package ciir_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int DATA_W    = 32;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = DATA_W + COEF_W;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  // sequencer to MAC controls
  typedef struct packed {
    logic issue;  // launch a product this cycle
    logic neg;    // the launched product is subtracted
    logic clr;    // clear the accumulator
  } mac_ctrl_t;

endpackage

// ===== sv/ciir_mac.sv =====
// ----------------------------------------------------------------------------
// ciir_mac
// Shared multiply-accumulate: one registered 32x16 product per cycle, scaled
// down by an arithmetic shift and added to or subtracted from the accumulator.
// ----------------------------------------------------------------------------
module ciir_mac
  import ciir_pkg::*;
#(
  parameter int FRAC_BITS = 14,
  parameter int ACC_W     = 51
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctrl_t                ctrl,
  input  logic signed [DATA_W-1:0] op_data,
  input  logic signed [COEF_W-1:0] op_coef,
  output logic signed [ACC_W-1:0]  sum
);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] shf;
  logic                     neg_r;
  logic                     pv_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  ext;
  logic signed [ACC_W-1:0]  term;

  always_ff @(posedge clk) begin
    prod_r <= op_data * op_coef;
    neg_r  <= ctrl.neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      pv_r <= ctrl.issue;
      if (ctrl.clr) begin
        acc_r <= '0;
      end else if (pv_r) begin
        acc_r <= sum;
      end
    end
  end

  // truncating shift rounds toward minus infinity
  assign shf  = prod_r >>> FRAC_BITS;
  assign ext  = {{(ACC_W-PROD_W){shf[PROD_W-1]}}, shf};
  assign term = neg_r ? -ext : ext;
  assign sum  = pv_r ? acc_r + term : acc_r;

endmodule

// ===== sv/cascaded_iir_filter_unit.sv =====
// ----------------------------------------------------------------------------
// cascaded_iir_filter_unit
// Cascade of direct-form-I IIR stages sharing one coefficient set and one MAC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one 16-bit signed sample per beat (in_valid/in_stall).
//   Output channel out_*: one 32-bit signed sample plus an overflow flag per
//   beat (out_valid/out_stall). Coefficients b0, b1, b2, a1, a2 are written
//   through cfg_wr_en/cfg_index/cfg_wdata while the block is idle; unknown
//   indexes are dropped.
//   Each stage runs 2*ORDER+1 products through a single shared multiplier,
//   one per cycle, and closes in the finishing state ST_FIN, which wraps the
//   sum and shifts the stage histories. in_stall is high from the accepting
//   edge until out_valid rises, so the block takes no new sample before the
//   last one has passed all stages; the shared MAC does one product per clock.
//   A finished result sits in the output register; the block takes the next
//   sample while it waits. If the receiver still stalls the old beat when
//   the next result is ready, the sequencer holds in its closing cycle.
//   Synchronous reset (rst_n low) clears coefficients, all histories, the
//   sequencer and the output valid.
// ----------------------------------------------------------------------------
module cascaded_iir_filter_unit
  import ciir_pkg::*;
#(
  parameter int ORDER     = 2,
  parameter int STAGES    = 2,
  parameter int FRAC_BITS = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DATA_W-1:0]   out_sample_out,
  output logic                       out_overflow,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEF_W-1:0]          cfg_wdata
);

  localparam int NSTEP = 2 * ORDER + 1;
  localparam int JW    = $clog2(NSTEP);
  localparam int SW    = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int HW    = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int ACC_W = PROD_W + $clog2(NSTEP) + 1;

  localparam logic [JW-1:0] LAST_STEP  = JW'(NSTEP - 1);
  localparam logic [JW-1:0] ORDER_J    = JW'(ORDER);
  localparam logic [SW-1:0] LAST_STAGE = SW'(STAGES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FIN
  } state_t;

  state_t                    state_r;
  logic [SW-1:0]             stage_r;
  logic [JW-1:0]             step_r;
  logic                      ovf_r;
  logic signed [DATA_W-1:0]  x_cur_r;
  // xh_r[s][i] holds stage s input from i+1 samples back; yh_r likewise
  logic signed [DATA_W-1:0]  xh_r [STAGES][ORDER];
  logic signed [DATA_W-1:0]  yh_r [STAGES][ORDER];
  logic signed [COEF_W-1:0]  b0_r, b1_r, b2_r, a1_r, a2_r;
  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_sample_r;
  logic                      out_ovf_r;

  logic                      accept;
  logic                      is_ff;
  logic [JW-1:0]             tap;
  logic [JW-1:0]             tap_m1;
  logic [HW-1:0]             hidx;
  logic signed [DATA_W-1:0]  op_data;
  logic signed [COEF_W-1:0]  op_coef;
  mac_ctrl_t                 ctrl;
  logic signed [ACC_W-1:0]   sum;
  logic signed [DATA_W-1:0]  y_wrap;
  logic                      stage_ovf;
  logic                      last_stage;
  logic                      slot_ok;
  logic                      leave;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign last_stage = (stage_r == LAST_STAGE);
  // last stage may close only when the output register is free this cycle
  assign slot_ok    = !last_stage || !out_valid_r || !out_stall;
  assign leave      = (state_r == ST_FIN) && slot_ok;

  // step order: feed-forward taps 0..ORDER, then feedback taps 1..ORDER
  assign is_ff  = (step_r <= ORDER_J);
  assign tap    = is_ff ? step_r : step_r - ORDER_J;
  assign tap_m1 = tap - JW'(1);
  assign hidx   = tap_m1[HW-1:0];

  always_comb begin
    op_coef = '0;
    if (is_ff) begin
      case (tap)
        JW'(0):  op_coef = b0_r;
        JW'(1):  op_coef = b1_r;
        JW'(2):  op_coef = b2_r;
        default: op_coef = '0;   // taps past b2 have no coefficient
      endcase
    end else begin
      case (tap)
        JW'(1):  op_coef = a1_r;
        JW'(2):  op_coef = a2_r;
        default: op_coef = '0;
      endcase
    end
  end

  always_comb begin
    if (is_ff && (tap == JW'(0))) begin
      op_data = x_cur_r;
    end else if (is_ff) begin
      op_data = xh_r[stage_r][hidx];
    end else begin
      op_data = yh_r[stage_r][hidx];
    end
  end

  assign ctrl.issue = (state_r == ST_MAC);
  assign ctrl.neg   = !is_ff;
  assign ctrl.clr   = leave || accept;

  ciir_mac #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (ACC_W)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .op_data (op_data),
    .op_coef (op_coef),
    .sum     (sum)
  );

  // wrap to 32 bits; flag when the upper bits are not a pure sign extension
  assign y_wrap    = sum[DATA_W-1:0];
  assign stage_ovf = !((&sum[ACC_W-1:DATA_W-1]) || !(|sum[ACC_W-1:DATA_W-1]));

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= '0;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_B0:  b0_r <= cfg_wdata;
        REG_B1:  b1_r <= cfg_wdata;
        REG_B2:  b2_r <= cfg_wdata;
        REG_A1:  a1_r <= cfg_wdata;
        REG_A2:  a2_r <= cfg_wdata;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // sequencer, histories and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stage_r     <= '0;
      step_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < STAGES; s++) begin
        for (int i = 0; i < ORDER; i++) begin
          xh_r[s][i] <= '0;
          yh_r[s][i] <= '0;
        end
      end
    end else begin
      // raise on a finished result, drop once the beat is taken
      if (leave && last_stage) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            x_cur_r <= DATA_W'(in_sample_in);
            stage_r <= '0;
            step_r  <= '0;
            ovf_r   <= 1'b0;
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (step_r == LAST_STEP) begin
            state_r <= ST_FIN;
          end else begin
            step_r <= step_r + JW'(1);
          end
        end
        ST_FIN: begin
          if (slot_ok) begin
            // shift this stage's histories; the new input and output enter
            for (int i = ORDER - 1; i > 0; i--) begin
              xh_r[stage_r][i] <= xh_r[stage_r][i-1];
              yh_r[stage_r][i] <= yh_r[stage_r][i-1];
            end
            xh_r[stage_r][0] <= x_cur_r;
            yh_r[stage_r][0] <= y_wrap;
            x_cur_r          <= y_wrap;
            ovf_r            <= ovf_r || stage_ovf;
            step_r           <= '0;
            if (last_stage) begin
              out_sample_r <= y_wrap;
              out_ovf_r    <= ovf_r || stage_ovf;
              state_r      <= ST_IDLE;
            end else begin
              stage_r <= stage_r + SW'(1);
              state_r <= ST_MAC;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_overflow   = out_ovf_r;

endmodule

// ===== sv/ciir_checker.sv =====
// ----------------------------------------------------------------------------
// ciir_checker
// Port-level checks of the filter's handshake timing, bound to the top level.
// ----------------------------------------------------------------------------
module ciir_checker
  import ciir_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [DATA_W-1:0]   out_sample_out,
  input logic                       out_overflow
);

  // a stalled output beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out)
                                && $stable(out_overflow))
    else $error("output beat changed while stalled");

  // the block is busy right after taking a sample
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // no result can appear on the cycle right after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // a new result coincides with the block returning to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result raised while still busy");

endmodule

bind cascaded_iir_filter_unit ciir_checker u_ciir_checker (.*);

// ===== tb/sv/cascaded_iir_filter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_iir_filter_unit_test
// Self-checking bench for the cascaded direct-form-I IIR filter. A clocked
// driver feeds samples from a queue, a clocked monitor predicts each accepted
// sample through a local fixed-point cascade and checks every output beat.
// ----------------------------------------------------------------------------
module cascaded_iir_filter_unit_test
  import ciir_pkg::*;
();

  localparam int ORDER     = 2;
  localparam int STAGES    = 2;
  localparam int FRAC_BITS = 14;
  localparam int TAPS      = ORDER + 1;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 2 * (2 * ORDER + 2) * STAGES;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PCT     = 35;

  // indexes past the last coefficient; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // coefficient styles of the random phases
  typedef enum int {
    COEF_FULL,
    COEF_EXTREME,
    COEF_MILD
  } coef_style_t;

  typedef struct {
    logic signed [DATA_W-1:0] sample;
    logic                     ovf;
  } filt_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [DATA_W-1:0]   out_sample_out;
  logic                       out_overflow;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [COEF_W-1:0]          cfg_wdata = '0;

  // local copy of the filter: coefficients and per-stage histories
  logic signed [COEF_W-1:0] tap_b  [TAPS];
  logic signed [COEF_W-1:0] tap_a  [TAPS];
  logic signed [DATA_W-1:0] x_hist [STAGES][TAPS];
  logic signed [DATA_W-1:0] y_hist [STAGES][TAPS];

  logic signed [SAMPLE_W-1:0] samples_to_send [$];
  filt_result_t               expected_out [$];

  logic sample_taken = 1'b0;
  int   src_idle_pct  = IDLE_PCT;
  int   sink_idle_pct = IDLE_PCT;
  int   sink_hold_req  = 0;
  int   sink_hold_seen = 0;
  int   sink_hold_left = 0;
  int   err_count = 0;
  int   beat_count = 0;
  int   cycle_cnt = 0;

  cascaded_iir_filter_unit #(
    .ORDER     (ORDER),
    .STAGES    (STAGES),
    .FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_overflow   (out_overflow),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // Product of a history value and a coefficient, floored by the fraction
  // shift. The arithmetic shift rounds toward minus infinity.
  function automatic longint scaled_product(logic signed [DATA_W-1:0] v,
                                            logic signed [COEF_W-1:0] c);
    logic signed [PROD_W-1:0] p;
    p = v * c;
    return longint'(p >>> FRAC_BITS);
  endfunction

  // Run one sample through every stage, advancing the local histories.
  function automatic filt_result_t filter_step(logic signed [SAMPLE_W-1:0] smp);
    filt_result_t             res;
    logic signed [DATA_W-1:0] stage_in;
    longint                   acc;
    stage_in = DATA_W'(smp);
    res.ovf  = 1'b0;
    for (int s = 0; s < STAGES; s++) begin
      for (int k = ORDER; k > 0; k--) begin
        x_hist[s][k] = x_hist[s][k-1];
        y_hist[s][k] = y_hist[s][k-1];
      end
      x_hist[s][0] = stage_in;
      acc = 0;
      for (int k = 0; k < TAPS; k++) begin
        acc += scaled_product(x_hist[s][k], tap_b[k]);
        // no feedback term for the current output: a0 is unused
        if (k > 0) acc -= scaled_product(y_hist[s][k], tap_a[k]);
      end
      if (acc > longint'(32'sh7fffffff) || acc < -longint'(64'h80000000)) res.ovf = 1'b1;
      // the wrapped sum is stored, passed on and reported
      stage_in     = acc[DATA_W-1:0];
      y_hist[s][0] = stage_in;
    end
    res.sample = stage_in;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    err_count++;
    $display("[%0t] mismatch on %s at beat %0d: got %0d, want %0d",
             $time, what, beat_count, got, want);
  endtask

  // Driver: offer the next sample at the falling edge, hold while stalled.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || sample_taken) begin
      if (samples_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        in_valid     <= 1'b1;
        in_sample_in <= samples_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (sink_hold_req != sink_hold_seen) begin
      sink_hold_seen = sink_hold_req;
      sink_hold_left = HOLD_CYCLES;
    end
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // Monitor: check output beats against the oldest prediction first, then
  // predict the sample accepted at this edge.
  always @(posedge clk) begin
    filt_result_t want;
    sample_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_out.size() == 0) begin
          report_mismatch("unexpected beat", out_sample_out, 0);
        end else begin
          want = expected_out.pop_front();
          if (out_sample_out !== want.sample)
            report_mismatch("sample_out", out_sample_out, want.sample);
          if (out_overflow !== want.ovf)
            report_mismatch("overflow", out_overflow, want.ovf);
        end
        beat_count++;
      end
      if (in_valid && !in_stall) expected_out.push_back(filter_step(in_sample_in));
    end
  end

  // Timeout guard.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Write one register and mirror it in the local coefficients.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_B0:  tap_b[0] = data;
      REG_B1:  tap_b[1] = data;
      REG_B2:  tap_b[2] = data;
      REG_A1:  tap_a[1] = data;
      REG_A2:  tap_a[2] = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                           input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                           input logic [COEF_W-1:0] a2);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
    @(posedge clk);
  endtask

  // Wait until every sample is in and every result is out, then let the
  // sequencer settle before anything touches the registers.
  task automatic drain_all();
    while (samples_to_send.size() != 0 || in_valid || expected_out.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] pick_extreme();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'h4000;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int r;
    r = $urandom_range(9);
    if (r < 6) return SAMPLE_W'($urandom);
    if (r < 8) return SAMPLE_W'($urandom_range(511)) - 16'sd256;
    return pick_extreme();
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef(coef_style_t style, int span);
    case (style)
      COEF_EXTREME: return pick_extreme();
      COEF_MILD:    return COEF_W'($urandom_range(2 * span)) - COEF_W'(span);
      default:      return COEF_W'($urandom);
    endcase
  endfunction

  initial begin
    coef_style_t style;
    for (int k = 0; k < TAPS; k++) begin
      tap_b[k] = '0;
      tap_a[k] = '0;
      for (int s = 0; s < STAGES; s++) begin
        x_hist[s][k] = '0;
        y_hist[s][k] = '0;
      end
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Coefficients straight out of reset: everything filters to zero.
    samples_to_send.push_back(16'sh7fff);
    samples_to_send.push_back(-16'sh8000);
    samples_to_send.push_back(16'sd123);
    drain_all();

    // Unity pass-through: b0 = 1.0, the cascade returns the input.
    set_coefs(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    samples_to_send.push_back(16'sh7fff);
    samples_to_send.push_back(-16'sh8000);
    samples_to_send.push_back(16'sd0);
    samples_to_send.push_back(-16'sd1);
    samples_to_send.push_back(16'sd1);
    samples_to_send.push_back(16'sh5555);
    drain_all();

    // Writes to indexes above the last coefficient must leave it alone.
    for (int idx = REG_SPARE_LO; idx <= REG_SPARE_HI; idx++)
      write_reg(CFG_IDX_W'(idx), 16'h7fff);
    @(posedge clk);
    samples_to_send.push_back(16'sh2aaa);
    samples_to_send.push_back(-16'sd77);
    drain_all();

    // Largest positive coefficients: feedback runs away and wraps.
    set_coefs(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    samples_to_send.push_back(16'sh7fff);
    samples_to_send.push_back(16'sh7fff);
    samples_to_send.push_back(-16'sh8000);
    samples_to_send.push_back(16'sd0);
    drain_all();

    // Most negative coefficients.
    set_coefs(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    samples_to_send.push_back(-16'sh8000);
    samples_to_send.push_back(-16'sh8000);
    samples_to_send.push_back(16'sh7fff);
    samples_to_send.push_back(-16'sd1);
    drain_all();

    // Random phases, each with a fresh coefficient set.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 3)
        0:       style = COEF_FULL;
        1:       style = COEF_EXTREME;
        default: style = COEF_MILD;
      endcase
      set_coefs(rand_coef(style, 8192), rand_coef(style, 8192), rand_coef(style, 8192),
                rand_coef(style, 12000), rand_coef(style, 6000));
      // phase 3 runs with no idling on either side
      src_idle_pct  = (ph == 3) ? 0 : IDLE_PCT;
      sink_idle_pct = (ph == 3) ? 0 : IDLE_PCT;
      repeat (148) samples_to_send.push_back(rand_sample());
      // hold the receiver off while the sender keeps offering samples
      if (ph == 6) sink_hold_req++;
      drain_all();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ciir_pkg.sv
sv/ciir_mac.sv
sv/cascaded_iir_filter_unit.sv
sv/ciir_checker.sv
tb/sv/cascaded_iir_filter_unit_test.sv
